@@ sv/first_fit_extent_allocator_unit_defines.svh @@
// assertion macros for the first-fit extent allocator
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FFEA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FFEA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ffea_pkg.sv @@
// shared types and constants of the first-fit extent allocator
`timescale 1ns / 1ps

package ffea_pkg;

    localparam int unsigned BLK_W      = 32;
    localparam int unsigned FIELD_IDX_W = 6;
    // entries reachable through a 6-bit index field
    localparam int unsigned TABLE_SLOTS = 64;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    localparam logic CFG_AREA_SIZE = 1'b0;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [BLK_W-1:0]       block_count;
        logic                   skip_valid;
        logic [FIELD_IDX_W-1:0] skip_index;
        logic [FIELD_IDX_W-1:0] entry_index;
        logic [BLK_W-1:0]       entry_start;
        logic [BLK_W-1:0]       entry_length;
    } req_t;

    typedef struct packed {
        logic             status;
        logic [BLK_W-1:0] alloc_start;
    } rsp_t;

endpackage

@@ sv/first_fit_extent_allocator_unit.sv @@
// top level of the first-fit extent allocator
`timescale 1ns / 1ps
`include "first_fit_extent_allocator_unit_defines.svh"

// first-fit extent allocator
//
// input channel s_valid/s_ready/s_data carries one request item: allocate, set
// entry or clear entry. result channel m_valid/m_ready/m_data carries exactly
// one result item per request. the user must write the data-area size register
// through the apb-style port at byte address 0 only while the block is idle; it does not enforce this.
//
// one request is in work at a time; s_ready is high only in the idle state.
// set, clear, unused codes and a zero or oversized count pass through the dispatch
// and done states to m_valid; s_ready returns in the cycle that m_valid rises.
// an allocate walks the extent table through the single read port of the
// entry ram: one overlap check (span test) reads every entry, and each used
// entry that is not skipped is read as a candidate (its end is a possible start).
// the table depth DEPTH is MAX_ENTRIES capped at 64; a free span at block 0 ends
// after one span test.
//
// reset clears the used bits and the area size, so the table is empty at
// once; no clearing pass runs. the result sits in an output register; while
// the receiver stalls, a finished result holds and the next request waits.
module first_fit_extent_allocator_unit #(
    parameter int unsigned MAX_ENTRIES = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    // request channel
    input  logic          s_valid,
    output logic          s_ready,
    input  ffea_pkg::req_t s_data,
    // result channel
    output logic          m_valid,
    input  logic          m_ready,
    output ffea_pkg::rsp_t m_data,
    // configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    // entries beyond the reach of the index fields are never addressed
    localparam int unsigned DEPTH = (MAX_ENTRIES < ffea_pkg::TABLE_SLOTS) ?
                                    MAX_ENTRIES : ffea_pkg::TABLE_SLOTS;
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned BW    = ffea_pkg::BLK_W;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DISPATCH  = 8'b0000_0010,
        S_SCAN      = 8'b0000_0100,
        S_EVAL      = 8'b0000_1000,
        S_CAND_RD   = 8'b0001_0000,
        S_CAND_CHK  = 8'b0010_0000,
        S_CAND_TEST = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    ffea_pkg::req_t       req_reg, req_next;
    logic [BW-1:0]        total_reg, total_next;
    logic [DEPTH-1:0]     used_reg, used_next;
    logic [CNT_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 conflict_reg, conflict_next;
    logic [CNT_W-1:0]     cand_i_reg, cand_i_next;
    logic [BW:0]          cand_b_reg, cand_b_next;
    logic [BW+1:0]        cand_end_reg, cand_end_next;
    logic                 found_reg, found_next;
    logic [BW-1:0]        best_reg, best_next;
    ffea_pkg::rsp_t       res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    ffea_pkg::rsp_t       m_data_reg, m_data_next;

    // entry ram: {start, length}
    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    logic [2*BW-1:0]      ram_wr_data;
    logic                 ram_rd_en;
    logic [IDX_W-1:0]     ram_rd_addr;
    logic [2*BW-1:0]      ram_rd_data;
    logic [BW-1:0]        rd_start;
    logic [BW-1:0]        rd_length;
    logic [BW:0]          rd_end;

    logic                 cfg_wr;
    logic                 entry_in_range;
    logic [IDX_W-1:0]     entry_idx;
    logic                 scan_hit;
    logic [BW+1:0]        test_end;
    logic                 cand_ok;

    // entry is left out of overlap checks
    function automatic logic skip_hit(input logic [IDX_W-1:0] idx,
                                      input ffea_pkg::req_t req);
        logic [ffea_pkg::FIELD_IDX_W:0] idx_w;
        logic [ffea_pkg::FIELD_IDX_W:0] skip_w;
        idx_w  = (ffea_pkg::FIELD_IDX_W + 1)'(idx);
        skip_w = (ffea_pkg::FIELD_IDX_W + 1)'(req.skip_index);
        return req.skip_valid && (idx_w == skip_w);
    endfunction

    ffea_ram #(
        .WIDTH (2 * BW),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_start  = ram_rd_data[2*BW-1:BW];
    assign rd_length = ram_rd_data[BW-1:0];
    assign rd_end    = {1'b0, rd_start} + {1'b0, rd_length};

    // config port, always ready, word-aligned decode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ffea_pkg::CFG_AREA_SIZE);
    assign prdata = (paddr[2] == ffea_pkg::CFG_AREA_SIZE) ? total_reg : '0;

    assign entry_in_range = ((ffea_pkg::FIELD_IDX_W + 1)'(req_reg.entry_index)
                             < (ffea_pkg::FIELD_IDX_W + 1)'(DEPTH));
    assign entry_idx = req_reg.entry_index[IDX_W-1:0];

    // overlap of the entry just read with the span under test
    assign scan_hit = used_reg[rd_idx_reg] && !skip_hit(rd_idx_reg, req_reg)
                      && (cand_b_reg < rd_end)
                      && ({2'b00, rd_start} < cand_end_reg);

    // candidate fit and first-fit pruning
    assign test_end = {1'b0, cand_b_reg} + {2'b00, req_reg.block_count};
    assign cand_ok  = (test_end <= {2'b00, total_reg})
                      && !(found_reg && (cand_b_reg >= {1'b0, best_reg}));

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        total_next    = total_reg;
        used_next     = used_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        conflict_next = conflict_reg;
        cand_i_next   = cand_i_reg;
        cand_b_next   = cand_b_reg;
        cand_end_next = cand_end_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = entry_idx;
        ram_wr_data   = {req_reg.entry_start, req_reg.entry_length};
        ram_rd_en     = 1'b0;
        ram_rd_addr   = rd_ptr_reg[IDX_W-1:0];

        if (cfg_wr) begin
            total_next = pwdata;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                res_next.status      = ffea_pkg::STATUS_OK;
                res_next.alloc_start = '0;
                state_next           = S_DONE;
                case (req_reg.req_type)
                    ffea_pkg::REQ_ALLOC: begin
                        if ((req_reg.block_count == '0)
                            || (req_reg.block_count > total_reg)) begin
                            res_next.status = ffea_pkg::STATUS_NO_SPACE;
                        end else begin
                            // first candidate is block 0
                            cand_b_next   = '0;
                            cand_end_next = {2'b00, req_reg.block_count};
                            found_next    = 1'b0;
                            cand_i_next   = '0;
                            rd_ptr_next   = '0;
                            conflict_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                    end
                    ffea_pkg::REQ_SET: begin
                        if (entry_in_range) begin
                            ram_wr_en            = 1'b1;
                            used_next[entry_idx] = 1'b1;
                        end
                    end
                    ffea_pkg::REQ_CLEAR: begin
                        if (entry_in_range) begin
                            used_next[entry_idx] = 1'b0;
                        end
                    end
                    default: begin
                        // unused code leaves the table alone
                    end
                endcase
            end
            S_SCAN: begin
                // issue one read per cycle, check the one read last cycle
                if (rd_ptr_reg != CNT_W'(DEPTH)) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rd_ptr_reg[IDX_W-1:0];
                    rd_idx_next = rd_ptr_reg[IDX_W-1:0];
                    rd_vld_next = 1'b1;
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
                if (rd_vld_reg) begin
                    conflict_next = conflict_reg || scan_hit;
                    if (rd_idx_reg == IDX_W'(DEPTH - 1)) begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (!conflict_reg && (cand_b_reg == '0)) begin
                    // nothing lower than block 0
                    res_next.status      = ffea_pkg::STATUS_OK;
                    res_next.alloc_start = '0;
                    state_next           = S_DONE;
                end else begin
                    if (!conflict_reg) begin
                        found_next = 1'b1;
                        best_next  = cand_b_reg[BW-1:0];
                    end
                    state_next = S_CAND_RD;
                end
            end
            S_CAND_RD: begin
                if (cand_i_reg == CNT_W'(DEPTH)) begin
                    res_next.status      = found_reg ? ffea_pkg::STATUS_OK
                                                     : ffea_pkg::STATUS_NO_SPACE;
                    res_next.alloc_start = found_reg ? best_reg : '0;
                    state_next           = S_DONE;
                end else begin
                    cand_i_next = cand_i_reg + CNT_W'(1);
                    if (used_reg[cand_i_reg[IDX_W-1:0]]
                        && !skip_hit(cand_i_reg[IDX_W-1:0], req_reg)) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cand_i_reg[IDX_W-1:0];
                        state_next  = S_CAND_CHK;
                    end
                end
            end
            S_CAND_CHK: begin
                // candidate start is the end of this used extent
                cand_b_next = rd_end;
                state_next  = S_CAND_TEST;
            end
            S_CAND_TEST: begin
                if (cand_ok) begin
                    cand_end_next = test_end;
                    rd_ptr_next   = '0;
                    conflict_next = 1'b0;
                    state_next    = S_SCAN;
                end else begin
                    state_next = S_CAND_RD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            total_reg    <= '0;
            used_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            used_reg     <= used_next;
            rd_vld_reg   <= rd_vld_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        rd_ptr_reg   <= rd_ptr_next;
        rd_idx_reg   <= rd_idx_next;
        conflict_reg <= conflict_next;
        cand_i_reg   <= cand_i_next;
        cand_b_reg   <= cand_b_next;
        cand_end_reg <= cand_end_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    // checks
    `FFEA_ASSERT_NEXT(a_accept_dispatch, s_valid && s_ready, state_reg == S_DISPATCH, "accepted item not dispatched")
    `FFEA_ASSERT_NOW(a_scan_last_read, (state_reg == S_SCAN) && rd_vld_reg && (rd_idx_reg == IDX_W'(DEPTH - 1)), rd_ptr_reg == CNT_W'(DEPTH), "span test ended before all entries were read")
    `FFEA_ASSERT_NOW(a_best_fits, ((state_reg == S_CAND_RD) && found_reg), (({1'b0, best_reg} + {1'b0, req_reg.block_count}) <= {1'b0, total_reg}), "best start does not fit in the data area")
    `FFEA_ASSERT_NOW(a_no_space_zero, (state_reg == S_DONE) && (res_reg.status == ffea_pkg::STATUS_NO_SPACE), res_reg.alloc_start == '0, "no-space result with nonzero start")

endmodule

@@ sv/ffea_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module ffea_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ dv/testbench.sv @@
// self-checking testbench of the first-fit extent allocator
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] REQ_NONE = 2'd3;   // unused request code, answers ok
    localparam logic [2:0] ADDR_AREA_SIZE = 3'(4 * int'(ffea_pkg::CFG_AREA_SIZE));
    localparam int unsigned LONG_HOLD = 600;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    ffea_pkg::req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ffea_pkg::rsp_t m_data;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    first_fit_extent_allocator_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mirror of the extent table and of the data-area size
    logic        ext_used  [ffea_pkg::TABLE_SLOTS];
    logic [31:0] ext_start [ffea_pkg::TABLE_SLOTS];
    logic [31:0] ext_len   [ffea_pkg::TABLE_SLOTS];
    logic [31:0] cfg_total = '0;

    ffea_pkg::req_t pending_reqs[$];
    ffea_pkg::rsp_t expected_rsps[$];
    int unsigned issued = 0;
    int unsigned retired = 0;
    int unsigned n_errors = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit long_hold_done = 1'b0;
    bit quiet = 1'b0;

    initial begin
        for (int i = 0; i < ffea_pkg::TABLE_SLOTS; i++) begin
            ext_used[i] = 1'b0;
            ext_start[i] = '0;
            ext_len[i] = '0;
        end
    end

    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= 40)
            $display("[%0t] %s", $time, msg);
    endtask

    // no used extent (other than the skipped one) overlaps [b, b + n)
    function automatic bit span_clear(logic [63:0] b, logic [63:0] n, logic skip_on,
                                      logic [5:0] skip);
        logic [63:0] s, e;
        for (int i = 0; i < ffea_pkg::TABLE_SLOTS; i++) begin
            if (!ext_used[i] || (skip_on && i == skip))
                continue;
            s = {32'd0, ext_start[i]};
            e = s + {32'd0, ext_len[i]};
            if (b < e && s < b + n)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // lowest start that fits: block 0 or the end of some used extent
    function automatic ffea_pkg::rsp_t first_fit(ffea_pkg::req_t r);
        ffea_pkg::rsp_t res;
        logic [63:0] n, tot, best, c;
        bit found;
        res.status = ffea_pkg::STATUS_OK;
        res.alloc_start = '0;
        n = {32'd0, r.block_count};
        tot = {32'd0, cfg_total};
        if (n == 0 || n > tot) begin
            res.status = ffea_pkg::STATUS_NO_SPACE;
            return res;
        end
        found = span_clear(64'd0, n, r.skip_valid, r.skip_index);
        best = '0;
        for (int i = 0; i < ffea_pkg::TABLE_SLOTS && !(found && best == 0); i++) begin
            if (!ext_used[i] || (r.skip_valid && i == r.skip_index))
                continue;
            c = {32'd0, ext_start[i]} + {32'd0, ext_len[i]};
            if (c + n > tot || (found && c >= best))
                continue;
            if (span_clear(c, n, r.skip_valid, r.skip_index)) begin
                found = 1'b1;
                best = c;
            end
        end
        if (found)
            res.alloc_start = best[31:0];
        else
            res.status = ffea_pkg::STATUS_NO_SPACE;
        return res;
    endfunction

    // applies one request to the mirror table and returns its result
    function automatic ffea_pkg::rsp_t serve_request(ffea_pkg::req_t r);
        ffea_pkg::rsp_t res;
        res.status = ffea_pkg::STATUS_OK;
        res.alloc_start = '0;
        case (r.req_type)
            ffea_pkg::REQ_ALLOC: begin
                res = first_fit(r);
            end
            ffea_pkg::REQ_SET: begin
                if (r.entry_index < ffea_pkg::TABLE_SLOTS) begin
                    ext_used[r.entry_index] = 1'b1;
                    ext_start[r.entry_index] = r.entry_start;
                    ext_len[r.entry_index] = r.entry_length;
                end
            end
            ffea_pkg::REQ_CLEAR: begin
                if (r.entry_index < ffea_pkg::TABLE_SLOTS) begin
                    ext_used[r.entry_index] = 1'b0;
                    ext_start[r.entry_index] = '0;
                    ext_len[r.entry_index] = '0;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned p = $urandom_range(99, 0);
        if (p < 45)
            return 0;
        if (p < 85)
            return $urandom_range(3, 1);
        if (p < 97)
            return $urandom_range(12, 4);
        return $urandom_range(120, 30);
    endfunction

    // every field random; the builders below overwrite what matters
    function automatic ffea_pkg::req_t any_req();
        ffea_pkg::req_t r;
        r.req_type = 2'($urandom);
        r.block_count = $urandom;
        r.skip_valid = 1'($urandom);
        r.skip_index = 6'($urandom);
        r.entry_index = 6'($urandom);
        r.entry_start = $urandom;
        r.entry_length = $urandom;
        return r;
    endfunction

    function automatic ffea_pkg::req_t alloc_req(logic [31:0] n, logic skv, logic [5:0] ski);
        ffea_pkg::req_t r = any_req();
        r.req_type = ffea_pkg::REQ_ALLOC;
        r.block_count = n;
        r.skip_valid = skv;
        r.skip_index = ski;
        return r;
    endfunction

    function automatic ffea_pkg::req_t set_req(logic [5:0] idx, logic [31:0] st,
                                               logic [31:0] len);
        ffea_pkg::req_t r = any_req();
        r.req_type = ffea_pkg::REQ_SET;
        r.entry_index = idx;
        r.entry_start = st;
        r.entry_length = len;
        return r;
    endfunction

    function automatic ffea_pkg::req_t clear_req(logic [5:0] idx);
        ffea_pkg::req_t r = any_req();
        r.req_type = ffea_pkg::REQ_CLEAR;
        r.entry_index = idx;
        return r;
    endfunction

    // sizes scaled to the current total, entries kept mostly in the low slots
    function automatic ffea_pkg::req_t random_req(logic [31:0] t);
        ffea_pkg::req_t r;
        logic [31:0] span;
        int unsigned kind;
        span = (t >> 3) + 32'd1;
        r = any_req();
        if ($urandom_range(3, 0) != 0)
            r.entry_index = 6'($urandom_range(15, 0));
        if ($urandom_range(1, 0) != 0)
            r.skip_index = 6'($urandom_range(15, 0));
        kind = $urandom_range(99, 0);
        if (kind < 40) begin
            r.req_type = ffea_pkg::REQ_ALLOC;
            case ($urandom_range(9, 0))
                0: r.block_count = '0;
                1: r.block_count = t;
                2: r.block_count = t + 32'd1;
                3: r.block_count = $urandom;
                default: r.block_count = $urandom_range(span, 1);
            endcase
        end else if (kind < 70) begin
            r.req_type = ffea_pkg::REQ_SET;
            if ($urandom_range(9, 0) != 0) begin
                r.entry_start = $urandom_range(t, 0);
                r.entry_length = $urandom_range(span, 0);
            end
        end else if (kind < 95) begin
            r.req_type = ffea_pkg::REQ_CLEAR;
        end else begin
            r.req_type = REQ_NONE;
        end
        return r;
    endfunction

    // request driver: holds each item until taken, random gaps between items
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) begin
                expected_rsps.push_back(serve_request(s_data));
                issued <= issued + 1;
            end
            if (gap_left != 0 || pending_reqs.size() == 0) begin
                s_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end else begin
                s_valid <= 1'b1;
                s_data <= pending_reqs.pop_front();
                gap_left <= quiet ? 0 : pick_gap();
            end
        end
    end

    // result receiver: random stalls, plus one long hold that backs up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!long_hold_done && retired >= 60) begin
            long_hold_done <= 1'b1;
            m_ready <= 1'b0;
            stall_left <= LONG_HOLD;
        end else if (!quiet && $urandom_range(3, 0) == 0) begin
            m_ready <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        ffea_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            retired <= retired + 1;
            if (expected_rsps.size() == 0) begin
                report_mismatch($sformatf("result with none expected: status %b start %h",
                                          m_data.status, m_data.alloc_start));
            end else begin
                want = expected_rsps.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch($sformatf("result %0d status: got %b, expected %b",
                                              retired, m_data.status, want.status));
                if (m_data.alloc_start !== want.alloc_start)
                    report_mismatch($sformatf("result %0d alloc_start: got %h, expected %h",
                                              retired, m_data.alloc_start,
                                              want.alloc_start));
            end
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_valid || retired != issued)
            @(negedge aclk);
    endtask

    task automatic write_total(logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_AREA_SIZE;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_total = value;
    endtask

    // drain, switch setting, then queue random items
    task automatic run_setting(logic [31:0] t, bit no_idle, int unsigned n_random);
        wait_idle();
        quiet = no_idle;
        write_total(t);
        @(negedge aclk);
        repeat (n_random)
            pending_reqs.push_back(random_req(t));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // area size out of reset is zero, nothing fits
        pending_reqs.push_back(alloc_req(32'd1, 1'b0, 6'd0));
        pending_reqs.push_back(alloc_req(32'd0, 1'b0, 6'd0));
        begin
            ffea_pkg::req_t odd;
            odd = any_req();
            odd.req_type = REQ_NONE;
            pending_reqs.push_back(odd);
        end

        // small data area, hand-built layouts
        run_setting(32'd100, 1'b0, 0);
        pending_reqs.push_back(alloc_req(32'd0, 1'b0, 6'd0));
        pending_reqs.push_back(alloc_req(32'd101, 1'b0, 6'd0));
        pending_reqs.push_back(alloc_req(32'd100, 1'b0, 6'd0));
        pending_reqs.push_back(set_req(6'd0, 32'd10, 32'd5));
        pending_reqs.push_back(alloc_req(32'd10, 1'b0, 6'd0));    // ends exactly at extent
        pending_reqs.push_back(alloc_req(32'd11, 1'b0, 6'd0));
        pending_reqs.push_back(alloc_req(32'd11, 1'b1, 6'd0));    // skipped entry
        pending_reqs.push_back(alloc_req(32'd11, 1'b0, 6'd0));    // skip index, not valid
        pending_reqs.push_back(set_req(6'd1, 32'd0, 32'd0));      // zero length
        pending_reqs.push_back(set_req(6'd63, 32'd20, 32'd80));
        pending_reqs.push_back(alloc_req(32'd11, 1'b0, 6'd0));    // no fitting start
        pending_reqs.push_back(alloc_req(32'd11, 1'b1, 6'd63));
        pending_reqs.push_back(alloc_req(32'd85, 1'b1, 6'd63));   // fills to the end
        pending_reqs.push_back(alloc_req(32'd86, 1'b1, 6'd63));
        pending_reqs.push_back(set_req(6'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(clear_req(6'd0));
        pending_reqs.push_back(alloc_req(32'd20, 1'b0, 6'd0));
        pending_reqs.push_back(clear_req(6'd63));
        pending_reqs.push_back(clear_req(6'd1));
        pending_reqs.push_back(clear_req(6'd2));
        pending_reqs.push_back(set_req(6'd5, 32'd0, 32'd100));
        pending_reqs.push_back(alloc_req(32'd1, 1'b0, 6'd0));

        // full 32-bit range, sums past 2^32 must not wrap
        run_setting(32'hFFFF_FFFF, 1'b0, 0);
        pending_reqs.push_back(alloc_req(32'hFFFF_FFFF, 1'b0, 6'd0));
        pending_reqs.push_back(alloc_req(32'hFFFF_FFFF, 1'b1, 6'd5));
        pending_reqs.push_back(set_req(6'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(alloc_req(32'hFFFF_FF9B, 1'b0, 6'd0));
        pending_reqs.push_back(clear_req(6'd5));
        repeat (120)
            pending_reqs.push_back(random_req(32'hFFFF_FFFF));

        run_setting(32'd0, 1'b1, 30);
        run_setting(32'd64, 1'b0, 150);
        run_setting(32'd1000, 1'b0, 150);
        run_setting($urandom, 1'b0, 80);
        run_setting(32'd1, 1'b1, 60);
        run_setting(32'd200, 1'b0, 40);

        wait_idle();
        repeat (20) @(posedge aclk);
        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/ffea_pkg.sv
sv/ffea_ram.sv
sv/first_fit_extent_allocator_unit.sv
dv/testbench.sv
